@@ rtl/core/button_debounce_midi_note_encoder_defines.svh @@
// Assertion macros shared by the encoder RTL.
// Needs clk and arst_n in the including scope.
`ifndef BUTTON_DEBOUNCE_MIDI_NOTE_ENCODER_DEFINES_SVH
`define BUTTON_DEBOUNCE_MIDI_NOTE_ENCODER_DEFINES_SVH

// same-cycle implication
`define BDM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/bdm_pkg.sv @@
// Shared types and constants for the debounced button MIDI encoder.
// No dependencies.
package bdm_pkg;

	localparam int NUM_BTN = 3;
	localparam int NUM_MSG = NUM_BTN + 1;
	localparam int MSG_IDX_W = $clog2(NUM_MSG);

	localparam int COUNT_W = 16;
	localparam int TICKS_W = 16;
	localparam int CMP_W = (COUNT_W > TICKS_W) ? COUNT_W : TICKS_W;
	localparam int CH_W = 5;
	localparam int DATA_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] ST_PROG = 8'hC0;
	localparam logic [7:0] ST_ON = 8'h90;
	localparam logic [7:0] ST_OFF = 8'h80;
	localparam logic [1:0] LEN_PROG = 2'd2;
	localparam logic [1:0] LEN_NOTE = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_C = 3'd5;

	// reset values
	localparam logic [TICKS_W-1:0] RST_TICKS = 16'd4;
	localparam logic [CH_W-1:0] RST_CHANNEL = 5'd1;
	localparam logic [DATA_W-1:0] RST_VELOCITY = 7'd100;
	localparam logic [DATA_W-1:0] RST_NOTE_A = 7'd60;
	localparam logic [DATA_W-1:0] RST_NOTE_B = 7'd62;
	localparam logic [DATA_W-1:0] RST_NOTE_C = 7'd64;

	typedef struct packed {
		logic flip;
		logic level;
	} lane_res_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [DATA_W-1:0] data_first;
		logic [DATA_W-1:0] data_second;
		logic [1:0] byte_count;
	} msg_t;

	// MIDI channel 1..16 to status nibble; out of range wraps mod 16
	function automatic logic [3:0] chan_nib(input logic [CH_W-1:0] ch);
		chan_nib = ch[3:0] - 4'd1;
	endfunction

endpackage

@@ rtl/core/bdm_in_if.sv @@
// Poll tick channel: valid/ready plus the button and program-change fields.
// Uses bdm_pkg for field widths.
interface bdm_in_if;
	logic valid;
	logic ready;
	logic [bdm_pkg::NUM_BTN-1:0] raw_levels;
	logic host_mounted;
	logic menu_busy;
	logic pc_request;
	logic [bdm_pkg::DATA_W-1:0] pc_program;
	logic [bdm_pkg::CH_W-1:0] pc_channel;

	modport source (output valid, raw_levels, host_mounted, menu_busy, pc_request,
		pc_program, pc_channel, input ready);
	modport sink (input valid, raw_levels, host_mounted, menu_busy, pc_request,
		pc_program, pc_channel, output ready);
endinterface

@@ rtl/core/bdm_out_if.sv @@
// MIDI message channel: valid/ready plus one message per transfer.
// Uses bdm_pkg for field widths.
interface bdm_out_if;
	logic valid;
	logic ready;
	logic [7:0] status_byte;
	logic [bdm_pkg::DATA_W-1:0] data_first;
	logic [bdm_pkg::DATA_W-1:0] data_second;
	logic [1:0] byte_count;
	logic last_of_tick;

	modport source (output valid, status_byte, data_first, data_second, byte_count,
		last_of_tick, input ready);
	modport sink (input valid, status_byte, data_first, data_second, byte_count,
		last_of_tick, output ready);
endinterface

@@ rtl/core/bdm_lane.sv @@
// One debounce lane: stable level and saturating mismatch counter for a button.
// Uses bdm_pkg.
module bdm_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic raw,
	input  logic [bdm_pkg::TICKS_W-1:0] ticks,
	output bdm_pkg::lane_res_t res
);

	logic stable_q;
	logic [bdm_pkg::COUNT_W-1:0] count_q;
	logic [bdm_pkg::COUNT_W-1:0] count_inc;
	logic hit;

	always_comb begin
		count_inc = (count_q == '1) ? count_q : count_q + bdm_pkg::COUNT_W'(1);
		hit = (raw != stable_q) &&
			(bdm_pkg::CMP_W'(count_inc) >= bdm_pkg::CMP_W'(ticks));
		res.flip = hit;
		res.level = raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			count_q <= '0;
		end else if (take) begin
			if (raw == stable_q || hit) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc;
			end
			if (hit) begin
				stable_q <= raw;
			end
		end
	end

endmodule

@@ rtl/core/bdm_merge.sv @@
// Merge stage: builds the messages of one tick from the lane results,
// holds them in a one-tick buffer and serializes them onto the output channel.
// Uses bdm_pkg and bdm_out_if.
module bdm_merge (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic mounted,
	input  logic busy,
	input  logic pc_req,
	input  logic [bdm_pkg::DATA_W-1:0] pc_prog,
	input  logic [bdm_pkg::CH_W-1:0] pc_ch,
	input  bdm_pkg::lane_res_t res [bdm_pkg::NUM_BTN],
	input  logic [bdm_pkg::CH_W-1:0] note_ch,
	input  logic [bdm_pkg::DATA_W-1:0] velocity,
	input  logic [bdm_pkg::DATA_W-1:0] notes [bdm_pkg::NUM_BTN],
	output logic slot_free,
	bdm_out_if.source out_ch
);

	bdm_pkg::msg_t msg_n [bdm_pkg::NUM_MSG];
	logic [bdm_pkg::NUM_MSG-1:0] mask_n;

	logic valid_s1;
	logic [bdm_pkg::NUM_MSG-1:0] mask_s1;
	bdm_pkg::msg_t msg_s1 [bdm_pkg::NUM_MSG];

	logic [bdm_pkg::NUM_MSG-1:0] mask_q;
	bdm_pkg::msg_t msg_q [bdm_pkg::NUM_MSG];

	logic [bdm_pkg::NUM_MSG-1:0] sel;
	logic [bdm_pkg::MSG_IDX_W-1:0] sel_idx;
	logic xfer;
	logic last;
	logic move;
	logic [3:0] nib;

	// slot 0 is the program change, slot i+1 is button i
	always_comb begin
		nib = bdm_pkg::chan_nib(note_ch);
		msg_n[0].status_byte = bdm_pkg::ST_PROG | {4'd0, bdm_pkg::chan_nib(pc_ch)};
		msg_n[0].data_first = pc_prog;
		msg_n[0].data_second = '0;
		msg_n[0].byte_count = bdm_pkg::LEN_PROG;
		mask_n[0] = pc_req && mounted;
		for (int i = 0; i < bdm_pkg::NUM_BTN; i++) begin
			msg_n[i+1].status_byte = (res[i].level ? bdm_pkg::ST_OFF : bdm_pkg::ST_ON) |
				{4'd0, nib};
			msg_n[i+1].data_first = notes[i];
			msg_n[i+1].data_second = res[i].level ? '0 : velocity;
			msg_n[i+1].byte_count = bdm_pkg::LEN_NOTE;
			mask_n[i+1] = res[i].flip && mounted && !busy;
		end
	end

	always_comb begin
		sel = mask_q & (~mask_q + bdm_pkg::NUM_MSG'(1));
		sel_idx = '0;
		for (int i = bdm_pkg::NUM_MSG - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel_idx = bdm_pkg::MSG_IDX_W'(i);
			end
		end
		last = (mask_q & ~sel) == '0;
		xfer = out_ch.valid && out_ch.ready;
		move = valid_s1 && (mask_q == '0 || (xfer && last));
	end

	// the buffer refills in the cycle it hands its tick to the serializer
	assign slot_free = !valid_s1 || move;
	assign out_ch.valid = |mask_q;
	assign out_ch.status_byte = msg_q[sel_idx].status_byte;
	assign out_ch.data_first = msg_q[sel_idx].data_first;
	assign out_ch.data_second = msg_q[sel_idx].data_second;
	assign out_ch.byte_count = msg_q[sel_idx].byte_count;
	assign out_ch.last_of_tick = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mask_s1 <= '0;
			mask_q <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				mask_s1 <= mask_n;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				mask_q <= mask_s1;
			end else if (xfer) begin
				mask_q <= mask_q & ~sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			msg_s1 <= msg_n;
		end
		if (move) begin
			msg_q <= msg_s1;
		end
	end

endmodule

@@ rtl/core/button_debounce_midi_note_encoder.sv @@
// Debounced three-button MIDI note encoder. One poll tick is taken per transfer on
// in_ch; the three button lanes debounce it in the accept cycle and the merge stage
// buffers the tick's messages (program change first, then buttons in order) and sends
// them on out_ch one per cycle while out_ch is ready, last_of_tick marking the
// final one. A tick carries 0 to 4 messages, and its first message is offered once
// it has passed the buffer register and the serializer register. A second tick waits
// in a one-tick buffer, so input ready drops only while that buffer is full and the
// serializer is not finishing its current tick.
// Uses bdm_pkg, bdm_in_if, bdm_out_if, bdm_lane, bdm_merge and the assertion header.
`include "button_debounce_midi_note_encoder_defines.svh"

module button_debounce_midi_note_encoder (
	input  logic clk,
	input  logic arst_n,
	bdm_in_if.sink in_ch,
	bdm_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [bdm_pkg::TICKS_W-1:0] ticks_q;
	logic [bdm_pkg::CH_W-1:0] channel_q;
	logic [bdm_pkg::DATA_W-1:0] velocity_q;
	logic [bdm_pkg::DATA_W-1:0] notes_q [bdm_pkg::NUM_BTN];

	bdm_pkg::lane_res_t res [bdm_pkg::NUM_BTN];
	logic slot_free;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= bdm_pkg::RST_TICKS;
			channel_q <= bdm_pkg::RST_CHANNEL;
			velocity_q <= bdm_pkg::RST_VELOCITY;
			notes_q[0] <= bdm_pkg::RST_NOTE_A;
			notes_q[1] <= bdm_pkg::RST_NOTE_B;
			notes_q[2] <= bdm_pkg::RST_NOTE_C;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdm_pkg::REG_TICKS: ticks_q <= cfg_wdata[bdm_pkg::TICKS_W-1:0];
				bdm_pkg::REG_CHANNEL: channel_q <= cfg_wdata[bdm_pkg::CH_W-1:0];
				bdm_pkg::REG_VELOCITY: velocity_q <= cfg_wdata[bdm_pkg::DATA_W-1:0];
				bdm_pkg::REG_NOTE_A: notes_q[0] <= cfg_wdata[bdm_pkg::DATA_W-1:0];
				bdm_pkg::REG_NOTE_B: notes_q[1] <= cfg_wdata[bdm_pkg::DATA_W-1:0];
				bdm_pkg::REG_NOTE_C: notes_q[2] <= cfg_wdata[bdm_pkg::DATA_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = slot_free;
	assign take = in_ch.valid && slot_free;

	for (genvar g = 0; g < bdm_pkg::NUM_BTN; g++) begin : g_lane
		bdm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.take   (take),
			.raw    (in_ch.raw_levels[g]),
			.ticks  (ticks_q),
			.res    (res[g])
		);
	end

	bdm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mounted   (in_ch.host_mounted),
		.busy      (in_ch.menu_busy),
		.pc_req    (in_ch.pc_request),
		.pc_prog   (in_ch.pc_program),
		.pc_ch     (in_ch.pc_channel),
		.res       (res),
		.note_ch   (channel_q),
		.velocity  (velocity_q),
		.notes     (notes_q),
		.slot_free (slot_free),
		.out_ch    (out_ch)
	);

	// a stalled message stays offered and unchanged
	`BDM_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable({out_ch.status_byte, out_ch.data_first, out_ch.data_second, out_ch.byte_count, out_ch.last_of_tick}), "message changed while stalled")
	// two-byte messages are always program changes
	`BDM_ASSERT_NOW(a_prog_len, out_ch.valid && out_ch.byte_count == bdm_pkg::LEN_PROG, out_ch.status_byte[7:4] == bdm_pkg::ST_PROG[7:4], "two-byte message without program status")
	// note off always carries zero velocity
	`BDM_ASSERT_NOW(a_off_vel, out_ch.valid && out_ch.status_byte[7:4] == bdm_pkg::ST_OFF[7:4], out_ch.data_second == '0 && out_ch.byte_count == bdm_pkg::LEN_NOTE, "note off with bad velocity or length")

endmodule

@@ dv/bdm_checker.sv @@
// Scoreboard for the debounced button MIDI encoder: mirrors the register writes,
// predicts the messages of each accepted tick and checks every message transfer.
// Depends on bdm_pkg, bdm_in_if and bdm_out_if.
module bdm_checker import bdm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bdm_in_if tick_if,
	bdm_out_if midi_if,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int errors,
	output int pending,
	output int checked
);

	typedef struct packed {
		logic [7:0] status;
		logic [DATA_W-1:0] note;
		logic [DATA_W-1:0] value;
		logic [1:0] len;
		logic last;
	} midi_msg_t;

	logic [TICKS_W-1:0] ticks_cfg;
	logic [CH_W-1:0] chan_cfg;
	logic [DATA_W-1:0] vel_cfg;
	logic [DATA_W-1:0] btn_note [NUM_BTN];
	logic [NUM_BTN-1:0] settled;
	logic [COUNT_W-1:0] bounce_cnt [NUM_BTN];
	midi_msg_t midi_q [$];
	midi_msg_t got, want;

	// debounce one tick and queue the messages it should cause
	function automatic void predict_tick();
		midi_msg_t m;
		int first;
		logic [3:0] nib;
		logic lvl;
		first = midi_q.size();
		nib = 4'(chan_cfg - 5'd1);
		if (tick_if.pc_request && tick_if.host_mounted) begin
			m.status = ST_PROG | {4'h0, 4'(tick_if.pc_channel - 5'd1)};
			m.note = tick_if.pc_program;
			m.value = '0;
			m.len = LEN_PROG;
			m.last = 1'b0;
			midi_q.push_back(m);
		end
		for (int i = 0; i < NUM_BTN; i++) begin
			lvl = tick_if.raw_levels[i];
			if (lvl == settled[i]) begin
				bounce_cnt[i] = '0;
			end else begin
				if (bounce_cnt[i] != '1)
					bounce_cnt[i] = bounce_cnt[i] + 1'b1;
				if (bounce_cnt[i] >= ticks_cfg) begin
					settled[i] = lvl;
					bounce_cnt[i] = '0;
					// flip still happens while muted, only the message is dropped
					if (tick_if.host_mounted && !tick_if.menu_busy) begin
						m.status = (lvl ? ST_OFF : ST_ON) | {4'h0, nib};
						m.note = btn_note[i];
						m.value = lvl ? '0 : vel_cfg;
						m.len = LEN_NOTE;
						m.last = 1'b0;
						midi_q.push_back(m);
					end
				end
			end
		end
		if (midi_q.size() > first)
			midi_q[midi_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_cfg = RST_TICKS;
			chan_cfg = RST_CHANNEL;
			vel_cfg = RST_VELOCITY;
			btn_note[0] = RST_NOTE_A;
			btn_note[1] = RST_NOTE_B;
			btn_note[2] = RST_NOTE_C;
			for (int i = 0; i < NUM_BTN; i++) begin
				settled[i] = 1'b1;
				bounce_cnt[i] = '0;
			end
			midi_q.delete();
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TICKS: ticks_cfg = cfg_wdata[TICKS_W-1:0];
					REG_CHANNEL: chan_cfg = cfg_wdata[CH_W-1:0];
					REG_VELOCITY: vel_cfg = cfg_wdata[DATA_W-1:0];
					REG_NOTE_A: btn_note[0] = cfg_wdata[DATA_W-1:0];
					REG_NOTE_B: btn_note[1] = cfg_wdata[DATA_W-1:0];
					REG_NOTE_C: btn_note[2] = cfg_wdata[DATA_W-1:0];
					default: ;
				endcase
			end
			if (tick_if.valid && tick_if.ready)
				predict_tick();
			if (midi_if.valid && midi_if.ready) begin
				got.status = midi_if.status_byte;
				got.note = midi_if.data_first;
				got.value = midi_if.data_second;
				got.len = midi_if.byte_count;
				got.last = midi_if.last_of_tick;
				checked <= checked + 1;
				if (midi_q.size() == 0) begin
					errors <= errors + 1;
					$display("%0t: unexpected message status %h note %0d value %0d len %0d last %b",
						$time, got.status, got.note, got.value, got.len, got.last);
				end else begin
					want = midi_q.pop_front();
					if (got !== want) begin
						errors <= errors + 1;
						$display("%0t: mismatch expected status %h note %0d value %0d len %0d last %b",
							$time, want.status, want.note, want.value, want.len, want.last);
						$display("%0t:          actual   status %h note %0d value %0d len %0d last %b",
							$time, got.status, got.note, got.value, got.len, got.last);
					end
				end
			end
			pending <= midi_q.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Top of the encoder testbench: clock, reset, register programming, tick and
// message traffic, watchdog and verdict. Checking lives in bdm_checker.
// Depends on bdm_pkg, bdm_in_if, bdm_out_if, bdm_checker and the encoder RTL.
module tb_top;
	import bdm_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int IDLE_PCT = 17;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bdm_in_if tick_if ();
	bdm_out_if midi_if ();

	int errors, pending, checked;
	int ticks_sent = 0;
	int settings_done = 1;
	int idle_run = 0;
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	logic [TICKS_W-1:0] cur_ticks = RST_TICKS;

	button_debounce_midi_note_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(tick_if),
		.out_ch(midi_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	bdm_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.tick_if(tick_if),
		.midi_if(midi_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// message receiver: random stalls, calm stretches and one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		midi_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				midi_if.ready <= 1'b0;
			end else if (hold_go) begin
				hold_go <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
				midi_if.ready <= 1'b0;
			end else begin
				midi_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_if.valid && tick_if.ready) || (midi_if.valid && midi_if.ready) || cfg_we)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, idle_run);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_tick(input logic [NUM_BTN-1:0] raw, input logic mnt, input logic busy,
			input logic req, input logic [DATA_W-1:0] prog, input logic [CH_W-1:0] ch);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			tick_if.valid <= 1'b0;
			@(posedge clk);
		end
		tick_if.valid <= 1'b1;
		tick_if.raw_levels <= raw;
		tick_if.host_mounted <= mnt;
		tick_if.menu_busy <= busy;
		tick_if.pc_request <= req;
		tick_if.pc_program <= prog;
		tick_if.pc_channel <= ch;
		@(posedge clk);
		while (!tick_if.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// stop offering ticks until every predicted message has gone out
	task automatic settle();
		tick_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [TICKS_W-1:0] ticks, input logic [CH_W-1:0] ch,
			input logic [DATA_W-1:0] vel, input logic [DATA_W-1:0] na,
			input logic [DATA_W-1:0] nb, input logic [DATA_W-1:0] nc);
		write_reg(REG_TICKS, CFG_DATA_W'(ticks));
		write_reg(REG_CHANNEL, CFG_DATA_W'(ch));
		write_reg(REG_VELOCITY, CFG_DATA_W'(vel));
		write_reg(REG_NOTE_A, CFG_DATA_W'(na));
		write_reg(REG_NOTE_B, CFG_DATA_W'(nb));
		write_reg(REG_NOTE_C, CFG_DATA_W'(nc));
		// spare index written last so an aliasing decode would clobber a real register
		write_reg(settings_done[0] ? REG_SPARE_B : REG_SPARE_A,
			CFG_DATA_W'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_ticks = ticks;
		settings_done++;
	endtask

	// button patterns held for runs near the debounce length (at most 4 above 6), with some bounce
	task automatic random_ticks(input int count);
		logic [NUM_BTN-1:0] target, raw;
		int run;
		int left;
		left = count;
		while (left > 0) begin
			target = 3'($urandom_range(0, 7));
			run = $urandom_range(1, (cur_ticks > 6) ? 4 : cur_ticks + 3);
			for (int k = 0; k < run && left > 0; k++) begin
				raw = target;
				if ($urandom_range(0, 99) < 10)
					raw = raw ^ (3'b001 << $urandom_range(0, 2));
				send_tick(raw, $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 15,
					$urandom_range(0, 99) < 25, 7'($urandom_range(0, 127)),
					5'($urandom_range(0, 31)));
				left--;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		tick_if.valid <= 1'b0;
		tick_if.raw_levels <= '1;
		tick_if.host_mounted <= 1'b0;
		tick_if.menu_busy <= 1'b0;
		tick_if.pc_request <= 1'b0;
		tick_if.pc_program <= '0;
		tick_if.pc_channel <= 5'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset register values
		send_tick(3'b111, 1, 0, 1, 7'd0, 5'd1);
		send_tick(3'b111, 0, 0, 1, 7'd127, 5'd16);   // unmounted, request dropped
		send_tick(3'b000, 1, 0, 1, 7'd127, 5'd16);
		send_tick(3'b000, 1, 0, 0, 7'd0, 5'd0);
		send_tick(3'b000, 1, 0, 1, 7'd85, 5'd0);     // channel 0 wraps to nibble F
		send_tick(3'b000, 1, 0, 1, 7'd42, 5'd17);    // program change plus three note ons
		send_tick(3'b111, 1, 1, 0, 7'd0, 5'd1);
		send_tick(3'b111, 1, 1, 1, 7'd1, 5'd31);
		send_tick(3'b111, 1, 1, 0, 7'd0, 5'd1);
		send_tick(3'b111, 1, 1, 0, 7'd0, 5'd1);      // release under menu, silent
		send_tick(3'b101, 1, 0, 0, 7'd0, 5'd1);
		send_tick(3'b111, 1, 0, 0, 7'd0, 5'd1);      // bounce clears the count
		repeat (4) send_tick(3'b101, 1, 0, 0, 7'd0, 5'd1);
		repeat (4) send_tick(3'b111, 1, 0, 0, 7'd0, 5'd1);

		settle();
		program_regs(16'd0, 5'd16, 7'd127, 7'd127, 7'd0, 7'd85);
		random_ticks(70);

		settle();
		program_regs(16'd1, 5'd0, 7'd0, 7'd0, 7'd1, 7'd2);
		calm <= 1'b1;
		random_ticks(70);
		calm <= 1'b0;

		settle();
		program_regs(16'd3, 5'd17, 7'd64, 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
		hold_go <= 1'b1;
		random_ticks(70);

		settle();
		program_regs(16'hFFFF, 5'd31, 7'd1, 7'd10, 7'd20, 7'd30);
		random_ticks(20);

		settle();
		program_regs(16'd2, 5'd9, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
		random_ticks(80);
		settle();
		hold_go <= 1'b1;
		random_ticks(60);

		settle();
		program_regs(16'd5, 5'd1, 7'd100, 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
		random_ticks(100);

		settle();
		$display("Run covered %0d ticks over %0d register settings, %0d messages checked,",
			ticks_sent, settings_done, checked);
		$display("including debounce 0 and 65535, channel wrap, muted flips and long stalls.");
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
